[rtl/pctbp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctbp_pkg
// Shared widths, codes and types of the per-client token bucket policer.
// ----------------------------------------------------------------------------
package pctbp_pkg;

  localparam int CLIENT_SLOTS        = 64;
  localparam int TOKEN_FRACTION_BITS = 16;
  localparam int SLOT_W              = $clog2(CLIENT_SLOTS);

  localparam int OP_W    = 2;
  localparam int IDX_W   = 6;
  localparam int TICK_W  = 32;
  localparam int RATE_W  = 24;
  localparam int CAP_W   = 16;
  localparam int DUR_W   = 32;
  localparam int THR_W   = 16;
  localparam int LEVEL_W = 32;
  localparam int VIOL_W  = 16;
  localparam int CNT_W   = 48;

  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int REG_W   = 2;

  localparam logic [OP_W-1:0] OP_REQUEST = OP_W'(0);
  localparam logic [OP_W-1:0] OP_BAN     = OP_W'(1);
  localparam logic [OP_W-1:0] OP_UNBAN   = OP_W'(2);
  localparam logic [OP_W-1:0] OP_REMOVE  = OP_W'(3);

  localparam logic [REG_W-1:0] REG_RATE     = REG_W'(0);
  localparam logic [REG_W-1:0] REG_CAPACITY = REG_W'(1);
  localparam logic [REG_W-1:0] REG_DURATION = REG_W'(2);
  localparam logic [REG_W-1:0] REG_THRESH   = REG_W'(3);

  localparam logic [RATE_W-1:0] RATE_RST     = RATE_W'(655);
  localparam logic [CAP_W-1:0]  CAPACITY_RST = CAP_W'(100);
  localparam logic [DUR_W-1:0]  DURATION_RST = DUR_W'(60000);
  localparam logic [THR_W-1:0]  THRESH_RST   = THR_W'(10);

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [CAP_W-1:0]  cap;
    logic [DUR_W-1:0]  dur;
    logic [THR_W-1:0]  thr;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] tokens;
    logic [TICK_W-1:0]  refill_tick;
    logic [VIOL_W-1:0]  viol;
    logic [TICK_W-1:0]  viol_tick;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              idx_ok;
    logic [SLOT_W-1:0] addr;
    logic [TICK_W-1:0] now;
  } item_t;

  typedef struct packed {
    logic              wr_en;
    entry_t            wr_entry;
    logic              slot_wr;
    logic              slot_use;
    logic              count_req;
    logic              count_blk;
    logic              allowed;
    logic              banned;
    logic [VIOL_W-1:0] viol;
  } upd_t;

endpackage

[rtl/per_client_token_bucket_policer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_client_token_bucket_policer
// Token bucket policer over a table of client slots with ban tracking.
// ----------------------------------------------------------------------------
// The block takes one request every clock cycle (busy stays low). A request
// accepted at a clock edge is registered into the first stage together with
// its slot table read, and its result is then registered onto the out_ ports,
// marked by out_valid; one result per request, in order.
// The rate is set by the slot table: one read and one write per cycle, with
// the previous request's write forwarded to the next one when both hit the
// same slot. Slot-in-use bits clear at reset, so no clearing pass is needed.
// Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module per_client_token_bucket_policer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [pctbp_pkg::OP_W-1:0]    in_operation,
  input  logic [pctbp_pkg::IDX_W-1:0]   in_client_index,
  input  logic [pctbp_pkg::TICK_W-1:0]  in_now_tick,
  output logic                          out_valid,
  output logic                          out_allowed,
  output logic                          out_client_banned,
  output logic [pctbp_pkg::VIOL_W-1:0]  out_violations,
  output logic [pctbp_pkg::CNT_W-1:0]   out_request_count,
  output logic [pctbp_pkg::CNT_W-1:0]   out_refused_count,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pctbp_pkg::ADDR_W-1:0]  paddr,
  input  logic [pctbp_pkg::DATA_W-1:0]  pwdata,
  output logic [pctbp_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);
  import pctbp_pkg::*;

  cfg_t                     cfg;
  logic                     accept;
  logic                     s1_valid_r;
  item_t                    s1_item_r;
  entry_t                   rd_entry;
  entry_t                   old_entry;
  logic                     in_use;
  upd_t                     upd;
  logic                     wr_en;
  logic                     fw_valid_r;
  logic [SLOT_W-1:0]        fw_addr_r;
  entry_t                   fw_entry_r;
  logic [CLIENT_SLOTS-1:0]  slot_in_use_r;
  logic [CNT_W-1:0]         req_total_r;
  logic [CNT_W-1:0]         blk_total_r;
  logic                     out_valid_r;
  logic                     out_allowed_r;
  logic                     out_banned_r;
  logic [VIOL_W-1:0]        out_viol_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  pctbp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r.op     <= in_operation;
      s1_item_r.idx_ok <= 32'(in_client_index) < 32'(CLIENT_SLOTS);
      s1_item_r.addr   <= SLOT_W'(in_client_index);
      s1_item_r.now    <= in_now_tick;
    end
  end

  pctbp_table u_table (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (SLOT_W'(in_client_index)),
    .rd_data (rd_entry),
    .wr_en   (wr_en),
    .wr_addr (s1_item_r.addr),
    .wr_data (upd.wr_entry)
  );

  assign old_entry = (fw_valid_r && (fw_addr_r == s1_item_r.addr)) ? fw_entry_r : rd_entry;
  assign in_use    = s1_item_r.idx_ok && slot_in_use_r[s1_item_r.addr];
  assign wr_en     = s1_valid_r && upd.wr_en;

  pctbp_update u_update (
    .item      (s1_item_r),
    .in_use    (in_use),
    .old_entry (old_entry),
    .cfg       (cfg),
    .upd       (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_valid_r <= 1'b0;
    end else begin
      fw_valid_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    fw_addr_r  <= s1_item_r.addr;
    fw_entry_r <= upd.wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_in_use_r <= '0;
      req_total_r   <= '0;
      blk_total_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r && upd.slot_wr) begin
        slot_in_use_r[s1_item_r.addr] <= upd.slot_use;
      end
      if (s1_valid_r && upd.count_req && (req_total_r != '1)) begin
        req_total_r <= req_total_r + CNT_W'(1);
      end
      if (s1_valid_r && upd.count_blk && (blk_total_r != '1)) begin
        blk_total_r <= blk_total_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_allowed_r <= upd.allowed;
    out_banned_r  <= upd.banned;
    out_viol_r    <= upd.viol;
  end

  assign out_valid         = out_valid_r;
  assign out_allowed       = out_allowed_r;
  assign out_client_banned = out_banned_r;
  assign out_violations    = out_viol_r;
  assign out_request_count = req_total_r;
  assign out_refused_count = blk_total_r;

endmodule

[rtl/pctbp_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctbp_cfg
// APB register bank: refill rate, burst capacity, ban duration, ban threshold.
// ----------------------------------------------------------------------------
module pctbp_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pctbp_pkg::ADDR_W-1:0]  paddr,
  input  logic [pctbp_pkg::DATA_W-1:0]  pwdata,
  output logic [pctbp_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output pctbp_pkg::cfg_t               cfg
);
  import pctbp_pkg::*;

  cfg_t             cfg_r;
  logic             wr;
  logic [REG_W-1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite && pready;
  assign reg_sel = paddr[ADDR_W-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rate <= RATE_RST;
      cfg_r.cap  <= CAPACITY_RST;
      cfg_r.dur  <= DURATION_RST;
      cfg_r.thr  <= THRESH_RST;
    end else if (wr) begin
      unique case (reg_sel)
        REG_RATE:     cfg_r.rate <= pwdata[RATE_W-1:0];
        REG_CAPACITY: cfg_r.cap  <= pwdata[CAP_W-1:0];
        REG_DURATION: cfg_r.dur  <= pwdata[DUR_W-1:0];
        REG_THRESH:   cfg_r.thr  <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_RATE:     prdata = DATA_W'(cfg_r.rate);
      REG_CAPACITY: prdata = DATA_W'(cfg_r.cap);
      REG_DURATION: prdata = DATA_W'(cfg_r.dur);
      REG_THRESH:   prdata = DATA_W'(cfg_r.thr);
      default:      prdata = '0;
    endcase
  end

endmodule

[rtl/pctbp_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctbp_table
// Client slot memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pctbp_table (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [pctbp_pkg::SLOT_W-1:0]  rd_addr,
  output pctbp_pkg::entry_t             rd_data,
  input  logic                          wr_en,
  input  logic [pctbp_pkg::SLOT_W-1:0]  wr_addr,
  input  pctbp_pkg::entry_t             wr_data
);
  import pctbp_pkg::*;

  entry_t mem [CLIENT_SLOTS];
  entry_t rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

[rtl/pctbp_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctbp_update
// Slot update for one request: create, ban test, refill, spend or violate; ban, unban, remove.
// ----------------------------------------------------------------------------
module pctbp_update (
  input  pctbp_pkg::item_t   item,
  input  logic               in_use,
  input  pctbp_pkg::entry_t  old_entry,
  input  pctbp_pkg::cfg_t    cfg,
  output pctbp_pkg::upd_t    upd
);
  import pctbp_pkg::*;

  localparam int FULL_W = CAP_W + TOKEN_FRACTION_BITS;
  localparam int PROD_W = TICK_W + RATE_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic [LEVEL_W-1:0] TOKEN_ONE = LEVEL_W'(1) << TOKEN_FRACTION_BITS;

  function automatic logic ban_test(input logic [VIOL_W-1:0] v,
                                    input logic [TICK_W-1:0] vt,
                                    input logic [TICK_W-1:0] now,
                                    input cfg_t              c);
    logic [TICK_W-1:0] since;
    since = now - vt;
    return (v != '0) && (VIOL_W'(c.thr) <= v) && (DUR_W'(since) < c.dur);
  endfunction

  logic [FULL_W-1:0]  full_wide;
  logic [LEVEL_W-1:0] full_lvl;
  entry_t             cur;
  entry_t             nxt;
  logic               banned_pre;
  logic [TICK_W-1:0]  elapsed;
  logic [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]   lvl_sum;
  logic [LEVEL_W-1:0] capped;
  logic               has_token;
  logic [VIOL_W-1:0]  viol_inc;
  logic [VIOL_W:0]    viol_add;
  logic [VIOL_W-1:0]  viol_ban;
  logic               use_after;

  always_comb begin
    full_wide = {cfg.cap, {TOKEN_FRACTION_BITS{1'b0}}};
    full_lvl  = (64'(full_wide) > 64'(32'hFFFF_FFFF)) ? '1 : LEVEL_W'(full_wide);

    if (in_use) begin
      cur = old_entry;
    end else begin
      cur.tokens      = full_lvl;
      cur.refill_tick = item.now;
      cur.viol        = '0;
      cur.viol_tick   = item.now;
    end

    banned_pre = ban_test(cur.viol, cur.viol_tick, item.now, cfg);
    elapsed    = item.now - cur.refill_tick;
    prod       = PROD_W'(elapsed) * PROD_W'(cfg.rate);
    lvl_sum    = SUM_W'(cur.tokens) + SUM_W'(prod);
    capped     = (lvl_sum > SUM_W'(full_lvl)) ? full_lvl : LEVEL_W'(lvl_sum);
    has_token  = capped >= TOKEN_ONE;
    viol_inc   = (cur.viol == '1) ? cur.viol : cur.viol + VIOL_W'(1);
    viol_add   = {1'b0, cur.viol} + (VIOL_W + 1)'(cfg.thr);
    viol_ban   = viol_add[VIOL_W] ? '1 : viol_add[VIOL_W-1:0];

    nxt           = cur;
    upd.wr_en     = 1'b0;
    upd.slot_wr   = 1'b0;
    upd.slot_use  = 1'b0;
    upd.count_req = 1'b0;
    upd.count_blk = 1'b0;
    upd.allowed   = 1'b0;

    unique case (item.op)
      OP_REQUEST: begin
        upd.count_req = 1'b1;
        if (!item.idx_ok) begin
          upd.count_blk = 1'b1;
        end else begin
          upd.wr_en    = 1'b1;
          upd.slot_wr  = 1'b1;
          upd.slot_use = 1'b1;
          if (banned_pre) begin
            upd.count_blk = 1'b1;
          end else begin
            nxt.refill_tick = item.now;
            if (has_token) begin
              nxt.tokens  = capped - TOKEN_ONE;
              upd.allowed = 1'b1;
            end else begin
              nxt.tokens    = capped;
              nxt.viol      = viol_inc;
              nxt.viol_tick = item.now;
              upd.count_blk = 1'b1;
            end
          end
        end
      end
      OP_BAN: begin
        if (item.idx_ok) begin
          upd.wr_en     = 1'b1;
          upd.slot_wr   = 1'b1;
          upd.slot_use  = 1'b1;
          nxt.viol      = viol_ban;
          nxt.viol_tick = item.now;
        end
      end
      OP_UNBAN: begin
        if (item.idx_ok && in_use) begin
          upd.wr_en = 1'b1;
          nxt.viol  = '0;
        end
      end
      OP_REMOVE: begin
        if (item.idx_ok) begin
          upd.slot_wr  = 1'b1;
          upd.slot_use = 1'b0;
        end
      end
      default: ;
    endcase

    upd.wr_entry = nxt;
    use_after    = upd.slot_wr ? upd.slot_use : in_use;
    if (item.idx_ok && use_after) begin
      upd.banned = ban_test(nxt.viol, nxt.viol_tick, item.now, cfg);
      upd.viol   = nxt.viol;
    end else begin
      upd.banned = 1'b0;
      upd.viol   = '0;
    end
  end

endmodule

[rtl/pctbp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctbp_checker
// Port-level checks of the policer: latency, counter and result consistency.
// ----------------------------------------------------------------------------
module pctbp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [pctbp_pkg::OP_W-1:0]    in_operation,
  input logic                          out_valid,
  input logic                          out_allowed,
  input logic                          out_client_banned,
  input logic [pctbp_pkg::CNT_W-1:0]   out_request_count,
  input logic [pctbp_pkg::CNT_W-1:0]   out_refused_count
);
  import pctbp_pkg::*;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2)) |-> (out_valid == $past(start && !busy, 2)))
    else $error("result strobe does not follow request by two cycles");

  a_allowed_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_allowed && $past(rst_n, 2)) |-> ($past(in_operation, 2) == OP_REQUEST))
    else $error("non-request operation reported as allowed");

  a_allowed_not_banned: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_allowed) |-> !out_client_banned)
    else $error("allowed request left client banned");

  a_blocked_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_refused_count <= out_request_count))
    else $error("blocked count exceeds request count");

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid) && $past(rst_n)) |->
      ((out_request_count - $past(out_request_count)) <= CNT_W'(1)))
    else $error("request count advanced by more than one");

endmodule

bind per_client_token_bucket_policer pctbp_checker u_pctbp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_operation      (in_operation),
  .out_valid         (out_valid),
  .out_allowed       (out_allowed),
  .out_client_banned (out_client_banned),
  .out_request_count (out_request_count),
  .out_refused_count (out_refused_count)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-client token bucket policer.
// Requests are queued by a stimulus process and fed to the block by a clocked
// driver with random gaps. Each accepted request runs through a behavioral
// policer kept inside the bench, and the verdict it produces waits in order
// until the block's result strobe. A monitor compares every field. The run
// goes through several register profiles, zero and full scale among them.
// Each profile is written and read back over the register port while no
// request is in flight.
// ----------------------------------------------------------------------------
module tb;
  import pctbp_pkg::*;

  localparam int          STALL_LIMIT   = 5000;
  localparam int          RANDOM_PHASES = 6;
  localparam int          PHASE_ITEMS   = 172;
  localparam logic [63:0] ONE_TOKEN     = 64'd1 << TOKEN_FRACTION_BITS;
  localparam logic [47:0] COUNT_MAX     = '1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [TICK_W-1:0] tick;
  } pol_req_t;

  typedef struct packed {
    logic              allowed;
    logic              banned;
    logic [VIOL_W-1:0] viol;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  blocked;
  } pol_verdict_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [OP_W-1:0]     in_operation = '0;
  logic [IDX_W-1:0]    in_client_index = '0;
  logic [TICK_W-1:0]   in_now_tick = '0;
  logic                out_valid;
  logic                out_allowed;
  logic                out_client_banned;
  logic [VIOL_W-1:0]   out_violations;
  logic [CNT_W-1:0]    out_request_count;
  logic [CNT_W-1:0]    out_refused_count;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  pol_req_t            request_q[$];
  pol_verdict_t        verdict_q[$];
  int                  idle_pct = 0;
  int                  fail_cnt = 0;
  int                  stall_cycles = 0;
  logic [TICK_W-1:0]   tick_cursor;

  // Bench copy of the registers and the slot table.
  logic [RATE_W-1:0]   cfg_rate = RATE_RST;
  logic [CAP_W-1:0]    cfg_cap = CAPACITY_RST;
  logic [DUR_W-1:0]    cfg_dur = DURATION_RST;
  logic [THR_W-1:0]    cfg_thr = THRESH_RST;
  logic                slot_open[CLIENT_SLOTS];
  logic [LEVEL_W-1:0]  slot_tokens[CLIENT_SLOTS];
  logic [TICK_W-1:0]   slot_refill_tick[CLIENT_SLOTS];
  logic [VIOL_W-1:0]   slot_viol[CLIENT_SLOTS];
  logic [TICK_W-1:0]   slot_viol_tick[CLIENT_SLOTS];
  logic [CNT_W-1:0]    seen_total = '0;
  logic [CNT_W-1:0]    refused_total = '0;

  per_client_token_bucket_policer i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_client_index   (in_client_index),
    .in_now_tick       (in_now_tick),
    .out_valid         (out_valid),
    .out_allowed       (out_allowed),
    .out_client_banned (out_client_banned),
    .out_violations    (out_violations),
    .out_request_count (out_request_count),
    .out_refused_count (out_refused_count),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic [63:0] full_level();
    logic [63:0] cap;
    cap = 64'(cfg_cap) << TOKEN_FRACTION_BITS;
    return (cap > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : cap;
  endfunction

  function automatic void open_slot(input logic [IDX_W-1:0] s, input logic [TICK_W-1:0] t);
    slot_open[s]        = 1'b1;
    slot_tokens[s]      = LEVEL_W'(full_level());
    slot_refill_tick[s] = t;
    slot_viol[s]        = '0;
    slot_viol_tick[s]   = t;
  endfunction

  function automatic logic slot_banned(input logic [IDX_W-1:0] s, input logic [TICK_W-1:0] t);
    logic [TICK_W-1:0] since;
    since = t - slot_viol_tick[s];
    if (!slot_open[s] || slot_viol[s] == '0 || 32'(slot_viol[s]) < 32'(cfg_thr)) return 1'b0;
    return since < cfg_dur;
  endfunction

  function automatic pol_verdict_t police_request(input pol_req_t r);
    pol_verdict_t v;
    logic [63:0]  level;
    logic [31:0]  elapsed;
    logic [16:0]  viol_sum;
    v = '0;
    case (r.op)
      OP_REQUEST: begin
        seen_total = sat_inc(seen_total);
        if (!slot_open[r.idx]) open_slot(r.idx, r.tick);
        if (slot_banned(r.idx, r.tick)) begin
          refused_total = sat_inc(refused_total);
        end else begin
          elapsed = r.tick - slot_refill_tick[r.idx];
          level   = 64'(slot_tokens[r.idx]) + 64'(elapsed) * 64'(cfg_rate);
          if (level > full_level()) level = full_level();
          slot_refill_tick[r.idx] = r.tick;
          if (level >= ONE_TOKEN) begin
            level     = level - ONE_TOKEN;
            v.allowed = 1'b1;
          end else begin
            if (slot_viol[r.idx] != '1) slot_viol[r.idx] = slot_viol[r.idx] + 1'b1;
            slot_viol_tick[r.idx] = r.tick;
            refused_total = sat_inc(refused_total);
          end
          slot_tokens[r.idx] = level[LEVEL_W-1:0];
        end
      end
      OP_BAN: begin
        if (!slot_open[r.idx]) open_slot(r.idx, r.tick);
        viol_sum = 17'(slot_viol[r.idx]) + 17'(cfg_thr);
        slot_viol[r.idx]      = viol_sum[16] ? '1 : viol_sum[15:0];
        slot_viol_tick[r.idx] = r.tick;
      end
      OP_UNBAN: begin
        if (slot_open[r.idx]) slot_viol[r.idx] = '0;
      end
      default: begin
        slot_open[r.idx] = 1'b0;
      end
    endcase
    if (slot_open[r.idx]) begin
      v.banned = slot_banned(r.idx, r.tick);
      v.viol   = slot_viol[r.idx];
    end
    v.total   = seen_total;
    v.blocked = refused_total;
    return v;
  endfunction

  // Driver: record the accepted request, then present the next one or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) verdict_q.insert(verdict_q.size(),
                                           police_request({in_operation, in_client_index,
                                                           in_now_tick}));
      if (!start || !busy) begin
        if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start           <= 1'b1;
          in_operation    <= request_q[0].op;
          in_client_index <= request_q[0].idx;
          in_now_tick     <= request_q[0].tick;
          void'(request_q.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result strobe with the oldest verdict.
  always @(posedge clk) begin
    pol_verdict_t exp_v;
    if (rst_n && out_valid) begin
      if (verdict_q.size() == 0) begin
        $error("result strobe with no request outstanding");
        fail_cnt++;
      end else begin
        exp_v = verdict_q.pop_front();
        if (out_allowed !== exp_v.allowed) begin
          $error("allowed: expected %0d, actual %0d", exp_v.allowed, out_allowed);
          fail_cnt++;
        end
        if (out_client_banned !== exp_v.banned) begin
          $error("client_banned: expected %0d, actual %0d", exp_v.banned, out_client_banned);
          fail_cnt++;
        end
        if (out_violations !== exp_v.viol) begin
          $error("violations: expected %0d, actual %0d", exp_v.viol, out_violations);
          fail_cnt++;
        end
        if (out_request_count !== exp_v.total) begin
          $error("request_count: expected %0d, actual %0d", exp_v.total, out_request_count);
          fail_cnt++;
        end
        if (out_refused_count !== exp_v.blocked) begin
          $error("refused_count: expected %0d, actual %0d", exp_v.blocked,
                 out_refused_count);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic program_register(input logic [REG_W-1:0] reg_idx, input logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] read_val;
    case (reg_idx)
      REG_RATE:     mask = 32'(24'hFF_FFFF);
      REG_CAPACITY: mask = 32'(16'hFFFF);
      REG_DURATION: mask = 32'hFFFF_FFFF;
      default:      mask = 32'(16'hFFFF);
    endcase
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({reg_idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_idx)
      REG_RATE:     cfg_rate = value[RATE_W-1:0];
      REG_CAPACITY: cfg_cap  = value[CAP_W-1:0];
      REG_DURATION: cfg_dur  = value[DUR_W-1:0];
      default:      cfg_thr  = value[THR_W-1:0];
    endcase
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    read_val = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((read_val & mask) !== (value & mask)) begin
      $error("register %0d readback: expected %0h, actual %0h", reg_idx, value & mask,
             read_val & mask);
      fail_cnt++;
    end
  endtask

  task automatic apply_profile(input logic [31:0] rate, input logic [31:0] cap,
                               input logic [31:0] dur, input logic [31:0] thr);
    program_register(REG_RATE, rate);
    program_register(REG_CAPACITY, cap);
    program_register(REG_DURATION, dur);
    program_register(REG_THRESH, thr);
  endtask

  task automatic wait_quiet();
    while (request_q.size() != 0 || start || verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void queue_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                        input logic [TICK_W-1:0] tick);
    pol_req_t r;
    r.op   = op;
    r.idx  = idx;
    r.tick = tick;
    request_q.insert(request_q.size(), r);
  endfunction

  // Mostly requests on a few hot slots with slowly advancing time; some noise.
  function automatic void queue_random(input int n);
    int               pick;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 80)      op = OP_REQUEST;
      else if (pick < 88) op = OP_BAN;
      else if (pick < 95) op = OP_UNBAN;
      else                op = OP_REMOVE;
      idx  = ($urandom_range(99) < 80) ? IDX_W'($urandom_range(3)) : IDX_W'($urandom_range(63));
      pick = $urandom_range(99);
      if (pick < 70)      tick_cursor = tick_cursor + $urandom_range(2);
      else if (pick < 90) tick_cursor = tick_cursor + $urandom_range(3, 50);
      else if (pick < 95) tick_cursor = tick_cursor + $urandom_range(100000);
      else                tick_cursor = $urandom;
      queue_request(op, idx, tick_cursor);
    end
  endfunction

  initial begin
    logic [TICK_W-1:0] ban_at;
    for (int s = 0; s < CLIENT_SLOTS; s++) slot_open[s] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests under the reset profile.
    ban_at = 32'h8000_0000;
    idle_pct = 19;
    queue_request(OP_REQUEST, 6'd0, 32'd0);
    queue_request(OP_REQUEST, 6'd63, 32'hFFFF_FFFF);
    queue_request(OP_BAN, 6'd5, 32'd100);
    queue_request(OP_REQUEST, 6'd5, 32'd101);
    queue_request(OP_UNBAN, 6'd5, 32'd102);
    queue_request(OP_REQUEST, 6'd5, 32'd103);
    queue_request(OP_REMOVE, 6'd5, 32'd104);
    queue_request(OP_REQUEST, 6'd5, 32'd105);
    queue_request(OP_UNBAN, 6'd7, 32'd106);
    queue_request(OP_REMOVE, 6'd7, 32'd107);
    queue_request(OP_REQUEST, 6'd63, 32'd5);
    queue_request(OP_BAN, 6'd63, ban_at);
    queue_request(OP_REQUEST, 6'd63, ban_at + 32'd59999);
    queue_request(OP_REQUEST, 6'd63, ban_at + 32'd60000);
    queue_request(OP_BAN, 6'd42, 32'h5555_5555);
    queue_request(OP_BAN, 6'd42, 32'hAAAA_AAAA);
    queue_request(OP_REQUEST, 6'd42, 32'hAAAA_AAAB);
    queue_request(OP_REMOVE, 6'd42, 32'hAAAA_AAAC);
    queue_request(OP_REQUEST, 6'd21, 32'hFFFF_FFFE);
    queue_request(OP_REQUEST, 6'd21, 32'd3);
    wait_quiet();

    // Zero capacity and zero threshold.
    idle_pct = 0;
    apply_profile(32'd655, 32'd0, 32'd1000, 32'd0);
    queue_request(OP_REQUEST, 6'd9, 32'd10);
    queue_request(OP_REQUEST, 6'd9, 32'd20);
    queue_request(OP_BAN, 6'd9, 32'd30);
    queue_request(OP_REQUEST, 6'd0, 32'd40);
    wait_quiet();

    tick_cursor = 32'hFFFF_FF00;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 48;
        2: idle_pct = 19;
        default: idle_pct = 0;
      endcase
      case (ph)
        0: apply_profile(32'd655, 32'd100, 32'd60000, 32'd10);
        1: apply_profile(32'd0, 32'd1, 32'd0, 32'd1);
        2: apply_profile(32'hFF_FFFF, 32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF);
        3: apply_profile(32'd16384, 32'd3, 32'd500, 32'd2);
        4: apply_profile($urandom_range(1 << 15), 32'd0, $urandom_range(2000), 32'd0);
        default: apply_profile($urandom_range(1 << 17), $urandom_range(1, 8),
                               $urandom_range(2000), $urandom_range(1, 5));
      endcase
      queue_random(PHASE_ITEMS);
      wait_quiet();
    end

    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
